// ===== hdl/pose_waypoint_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Pose waypoint sampler assertion macros
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef POSE_WAYPOINT_SAMPLER_MACROS_SVH
`define POSE_WAYPOINT_SAMPLER_MACROS_SVH

`ifndef ASSERT_OFF
`define PWS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("pose waypoint sampler assertion failed");
`define PWS_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("pose waypoint sampler assertion failed");
`else
`define PWS_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define PWS_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== hdl/pws_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose waypoint sampler package
// Beat types, widths, register indexes, sequencer codes and the atan table.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int IDX_W      = 16;
    localparam int ANG_W      = 16;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CW         = 36;
    localparam int ACC_W      = 21;
    localparam int YAW_W      = ACC_W - 3;
    localparam int DIST_W     = 65;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int ITERS      = 16;
    localparam int ITER_W     = 4;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd2;

    localparam logic [ANG_W-1:0] ANGLE_RST   = 16'd2145;
    localparam logic [THR_W-1:0] CHORD_RST   = 31'd65536;
    localparam logic [THR_W-1:0] SPACING_RST = 31'd262144;

    localparam logic signed [ACC_W-1:0] ANG_PI = 21'sd205887;
    localparam logic [IDX_W-1:0]        IDX_MAX = '1;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } in_beat_t;

    typedef struct packed {
        logic        [IDX_W-1:0]  wp_index;
        logic signed [POS_W-1:0]  wp_x;
        logic signed [POS_W-1:0]  wp_y;
        logic signed [POS_W-1:0]  wp_z;
        logic signed [QUAT_W-1:0] wp_qx;
        logic signed [QUAT_W-1:0] wp_qy;
        logic signed [QUAT_W-1:0] wp_qz;
        logic signed [QUAT_W-1:0] wp_qw;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_ANGLE,
        ST_DECIDE
    } state_t;

    typedef enum logic [STEP_W-1:0] {
        MUL_XX,
        MUL_WW,
        MUL_YY,
        MUL_ZZ,
        MUL_XY,
        MUL_WZ,
        MUL_DX,
        MUL_DY,
        MUL_SP,
        MUL_CH
    } mul_step_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            4'd0:  v = 21'sd51472;
            4'd1:  v = 21'sd30386;
            4'd2:  v = 21'sd16055;
            4'd3:  v = 21'sd8150;
            4'd4:  v = 21'sd4091;
            4'd5:  v = 21'sd2047;
            4'd6:  v = 21'sd1024;
            4'd7:  v = 21'sd512;
            4'd8:  v = 21'sd256;
            4'd9:  v = 21'sd128;
            4'd10: v = 21'sd64;
            4'd11: v = 21'sd32;
            4'd12: v = 21'sd16;
            4'd13: v = 21'sd8;
            4'd14: v = 21'sd4;
            4'd15: v = 21'sd2;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/pose_waypoint_sampler.sv =====
// ----------------------------------------------------------------------------
// Pose waypoint sampler
// One pose beat at a time: s_ready is high only in ST_IDLE, so a new beat waits
// for ten passes through the shared 33x33 multiplier, sixteen CORDIC
// iterations and the record decision, which can stall on a full output.
// Reset: aresetn is synchronous, active low; state clears, thresholds return
// to their defaults at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "pose_waypoint_sampler_macros.svh"

module pose_waypoint_sampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pws_pkg::in_beat_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pws_pkg::out_beat_t                   m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pws_pkg::CFG_DATA_W-1:0]       cfg_data
);

    pws_pkg::state_t                    state_reg, state_next;
    pws_pkg::mul_step_t                 step_reg;
    pws_pkg::mul_step_t                 prod_step_reg;
    logic                               prod_vld_reg;

    logic [pws_pkg::ANG_W-1:0]          angle_reg;
    logic [pws_pkg::THR_W-1:0]          chord_reg;
    logic [pws_pkg::THR_W-1:0]          spacing_reg;

    logic                               have_first_reg;
    logic signed [pws_pkg::POS_W-1:0]   last_x_reg;
    logic signed [pws_pkg::POS_W-1:0]   last_y_reg;
    logic signed [pws_pkg::YAW_W-1:0]   base_yaw_reg;
    logic [pws_pkg::IDX_W-1:0]          count_reg;

    pws_pkg::in_beat_t                  in_reg;
    pws_pkg::out_beat_t                 out_reg;
    logic                               m_valid_reg;
    logic signed [pws_pkg::MUL_W-1:0]   dx_reg;
    logic signed [pws_pkg::MUL_W-1:0]   dy_reg;
    logic signed [pws_pkg::PROD_W-1:0]  prod_reg;
    logic signed [pws_pkg::CW-1:0]      a_reg;
    logic signed [pws_pkg::CW-1:0]      b_reg;
    logic [pws_pkg::DIST_W-1:0]         dist_reg;
    logic [pws_pkg::THR_SQ_W-1:0]       sp2_reg;
    logic [pws_pkg::THR_SQ_W-1:0]       ch2_reg;

    logic signed [pws_pkg::MUL_W-1:0]   op_a;
    logic signed [pws_pkg::MUL_W-1:0]   op_b;
    logic signed [pws_pkg::CW-1:0]      prod_cw;

    pws_pkg::cordic_stat_t              cordic_stat;
    logic signed [pws_pkg::YAW_W-1:0]   yaw;

    logic signed [pws_pkg::YAW_W:0]     dyaw;
    logic [pws_pkg::YAW_W:0]            dyaw_abs;
    logic                               far;
    logic                               near;
    logic                               turned;
    logic                               rec;
    logic                               first;
    logic                               out_free;

    logic                               in_take;
    logic                               mul_issue;
    logic                               cordic_start;
    logic                               commit;
    logic                               load_out;

    // ---- shared multiplier operand select ----
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            pws_pkg::MUL_XX: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_x);
                op_b = pws_pkg::MUL_W'(in_reg.quat_x);
            end
            pws_pkg::MUL_WW: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_w);
                op_b = pws_pkg::MUL_W'(in_reg.quat_w);
            end
            pws_pkg::MUL_YY: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_y);
                op_b = pws_pkg::MUL_W'(in_reg.quat_y);
            end
            pws_pkg::MUL_ZZ: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_z);
                op_b = pws_pkg::MUL_W'(in_reg.quat_z);
            end
            pws_pkg::MUL_XY: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_x);
                op_b = pws_pkg::MUL_W'(in_reg.quat_y);
            end
            pws_pkg::MUL_WZ: begin
                op_a = pws_pkg::MUL_W'(in_reg.quat_w);
                op_b = pws_pkg::MUL_W'(in_reg.quat_z);
            end
            pws_pkg::MUL_DX: begin
                op_a = dx_reg;
                op_b = dx_reg;
            end
            pws_pkg::MUL_DY: begin
                op_a = dy_reg;
                op_b = dy_reg;
            end
            pws_pkg::MUL_SP: begin
                op_a = $signed({{(pws_pkg::MUL_W - pws_pkg::THR_W){1'b0}}, spacing_reg});
                op_b = $signed({{(pws_pkg::MUL_W - pws_pkg::THR_W){1'b0}}, spacing_reg});
            end
            pws_pkg::MUL_CH: begin
                op_a = $signed({{(pws_pkg::MUL_W - pws_pkg::THR_W){1'b0}}, chord_reg});
                op_b = $signed({{(pws_pkg::MUL_W - pws_pkg::THR_W){1'b0}}, chord_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_cw = $signed(prod_reg[pws_pkg::CW-1:0]);

    pws_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .a_in    (a_reg),
        .b_in    (b_reg),
        .stat    (cordic_stat),
        .yaw     (yaw)
    );

    // ---- record decision ----
    always_comb begin
        dyaw     = {yaw[pws_pkg::YAW_W-1], yaw}
                 - {base_yaw_reg[pws_pkg::YAW_W-1], base_yaw_reg};
        dyaw_abs = dyaw[pws_pkg::YAW_W] ? $unsigned(-dyaw) : $unsigned(dyaw);
        turned   = dyaw_abs > {{(pws_pkg::YAW_W + 1 - pws_pkg::ANG_W){1'b0}}, angle_reg};
        far      = dist_reg > {{(pws_pkg::DIST_W - pws_pkg::THR_SQ_W){1'b0}}, sp2_reg};
        near     = dist_reg > {{(pws_pkg::DIST_W - pws_pkg::THR_SQ_W){1'b0}}, ch2_reg};
        rec      = far | (turned & near);
        first    = !have_first_reg;
        out_free = !m_valid_reg || m_ready;
    end

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pws_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pws_pkg::ST_MUL;
                end
            end
            pws_pkg::ST_MUL: begin
                if (step_reg == pws_pkg::MUL_CH) begin
                    state_next = pws_pkg::ST_DRAIN;
                end
            end
            pws_pkg::ST_DRAIN: begin
                state_next = pws_pkg::ST_ANGLE;
            end
            pws_pkg::ST_ANGLE: begin
                if (cordic_stat.done) begin
                    state_next = pws_pkg::ST_DECIDE;
                end
            end
            pws_pkg::ST_DECIDE: begin
                if (first || !rec || out_free) begin
                    state_next = pws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pws_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- sequencer outputs ----
    always_comb begin
        s_ready      = (state_reg == pws_pkg::ST_IDLE);
        in_take      = s_ready && s_valid;
        mul_issue    = (state_reg == pws_pkg::ST_MUL);
        cordic_start = (state_reg == pws_pkg::ST_DRAIN);
        commit       = (state_reg == pws_pkg::ST_DECIDE) && (first || (rec && out_free));
        load_out     = (state_reg == pws_pkg::ST_DECIDE) && !first && rec && out_free;
    end

    // ---- control ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pws_pkg::ST_IDLE;
            step_reg       <= pws_pkg::MUL_XX;
            prod_step_reg  <= pws_pkg::MUL_XX;
            prod_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            angle_reg      <= pws_pkg::ANGLE_RST;
            chord_reg      <= pws_pkg::CHORD_RST;
            spacing_reg    <= pws_pkg::SPACING_RST;
            have_first_reg <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            base_yaw_reg   <= '0;
            count_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            prod_vld_reg  <= mul_issue;
            prod_step_reg <= step_reg;
            if (in_take) begin
                step_reg <= pws_pkg::MUL_XX;
            end else if (mul_issue) begin
                step_reg <= pws_pkg::mul_step_t'(step_reg + 1'b1);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    pws_pkg::CFG_ANGLE:   angle_reg   <= cfg_data[pws_pkg::ANG_W-1:0];
                    pws_pkg::CFG_CHORD:   chord_reg   <= cfg_data[pws_pkg::THR_W-1:0];
                    pws_pkg::CFG_SPACING: spacing_reg <= cfg_data[pws_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (commit) begin
                have_first_reg <= 1'b1;
                last_x_reg     <= in_reg.pos_x;
                last_y_reg     <= in_reg.pos_y;
                base_yaw_reg   <= yaw;
                if (count_reg != pws_pkg::IDX_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_data;
            dx_reg <= {s_data.pos_x[pws_pkg::POS_W-1], s_data.pos_x}
                    - {last_x_reg[pws_pkg::POS_W-1], last_x_reg};
            dy_reg <= {s_data.pos_y[pws_pkg::POS_W-1], s_data.pos_y}
                    - {last_y_reg[pws_pkg::POS_W-1], last_y_reg};
            a_reg  <= '0;
            b_reg  <= '0;
        end else if (prod_vld_reg) begin
            unique case (prod_step_reg)
                pws_pkg::MUL_XX, pws_pkg::MUL_WW: a_reg <= a_reg + prod_cw;
                pws_pkg::MUL_YY, pws_pkg::MUL_ZZ: a_reg <= a_reg - prod_cw;
                pws_pkg::MUL_XY, pws_pkg::MUL_WZ:
                    b_reg <= b_reg + {prod_cw[pws_pkg::CW-2:0], 1'b0};
                pws_pkg::MUL_DX: dist_reg <= prod_reg[pws_pkg::DIST_W-1:0];
                pws_pkg::MUL_DY: dist_reg <= dist_reg + prod_reg[pws_pkg::DIST_W-1:0];
                pws_pkg::MUL_SP: sp2_reg  <= prod_reg[pws_pkg::THR_SQ_W-1:0];
                pws_pkg::MUL_CH: ch2_reg  <= prod_reg[pws_pkg::THR_SQ_W-1:0];
                default: ;
            endcase
        end
        if (mul_issue) begin
            prod_reg <= op_a * op_b;
        end
        if (load_out) begin
            out_reg.wp_index <= count_reg;
            out_reg.wp_x     <= in_reg.pos_x;
            out_reg.wp_y     <= in_reg.pos_y;
            out_reg.wp_z     <= in_reg.pos_z;
            out_reg.wp_qx    <= in_reg.quat_x;
            out_reg.wp_qy    <= in_reg.quat_y;
            out_reg.wp_qz    <= in_reg.quat_z;
            out_reg.wp_qw    <= in_reg.quat_w;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    `PWS_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PWS_ASSERT_IMP(a_result_from_decide, aclk, aresetn, $rose(m_valid), $past(state_reg) == pws_pkg::ST_DECIDE)
    `PWS_ASSERT_IMP(a_cordic_done_in_angle, aclk, aresetn, cordic_stat.done, state_reg == pws_pkg::ST_ANGLE)
    `PWS_ASSERT_IMP(a_cordic_busy, aclk, aresetn, cordic_stat.busy, state_reg == pws_pkg::ST_ANGLE)
    `PWS_ASSERT_IMP(a_count_monotone, aclk, aresetn, $past(aresetn), count_reg >= $past(count_reg))

endmodule

// ===== hdl/pws_cordic.sv =====
// ----------------------------------------------------------------------------
// Pose waypoint sampler CORDIC
// Iterative vectoring atan2, one micro-rotation per cycle, yaw in Q5.13.
// ----------------------------------------------------------------------------
`include "pose_waypoint_sampler_macros.svh"

module pws_cordic (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [pws_pkg::CW-1:0]          a_in,
    input  logic signed [pws_pkg::CW-1:0]          b_in,
    output pws_pkg::cordic_stat_t                  stat,
    output logic signed [pws_pkg::YAW_W-1:0]       yaw
);

    logic signed [pws_pkg::CW-1:0]    x_reg, x_next;
    logic signed [pws_pkg::CW-1:0]    y_reg, y_next;
    logic signed [pws_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [pws_pkg::YAW_W-1:0] yaw_reg;
    logic [pws_pkg::ITER_W-1:0]       iter_reg;
    logic                             run_reg;
    logic                             rnd_reg;
    logic                             done_reg;

    logic signed [pws_pkg::CW-1:0]    xs;
    logic signed [pws_pkg::CW-1:0]    ys;
    logic signed [pws_pkg::ACC_W-1:0] step_ang;
    logic signed [pws_pkg::ACC_W-1:0] acc_rnd;

    assign xs       = x_reg >>> iter_reg;
    assign ys       = y_reg >>> iter_reg;
    assign step_ang = pws_pkg::atan_step(iter_reg);
    assign acc_rnd  = acc_reg + pws_pkg::ACC_W'(4);

    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        if (y_reg > 0) begin
            x_next   = x_reg + ys;
            y_next   = y_reg - xs;
            acc_next = acc_reg + step_ang;
        end else if (y_reg < 0) begin
            x_next   = x_reg - ys;
            y_next   = y_reg + xs;
            acc_next = acc_reg - step_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= rnd_reg;
            rnd_reg  <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                iter_reg <= '0;
            end else if (run_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == pws_pkg::ITER_W'(pws_pkg::ITERS - 1)) begin
                    run_reg <= 1'b0;
                    rnd_reg <= 1'b1;
                end
            end
        end
    end

    // left half plane: rotate by pi first
    always_ff @(posedge aclk) begin
        if (start) begin
            if (a_in < 0) begin
                x_reg   <= -a_in;
                y_reg   <= -b_in;
                acc_reg <= (b_in >= 0) ? pws_pkg::ANG_PI : -pws_pkg::ANG_PI;
            end else begin
                x_reg   <= a_in;
                y_reg   <= b_in;
                acc_reg <= '0;
            end
        end else if (run_reg) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
        if (rnd_reg) begin
            yaw_reg <= acc_rnd[pws_pkg::ACC_W-1:3];
        end
    end

    assign stat.busy = run_reg | rnd_reg;
    assign stat.done = done_reg;
    assign yaw       = yaw_reg;

    `PWS_ASSERT_NXT(a_round_then_done, aclk, aresetn, rnd_reg, done_reg && !run_reg)

endmodule
